@@ design/tcct_pkg.sv @@
// Shared types and constants of the transport client connection table.
package tcct_pkg;

  localparam int unsigned CONNECTIONS = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned SEQ_MODULUS = 65536;
  localparam logic [15:0] SEQ_MAX     = 16'(SEQ_MODULUS - 1);

  typedef enum logic [2:0] {
    OP_OPEN       = 3'd0,
    OP_CONNECT    = 3'd1,
    OP_DISCONNECT = 3'd2,
    OP_CLOSE      = 3'd3,
    OP_SEGMENT    = 3'd4,
    OP_TICK       = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    CS_CLOSED    = 2'd0,
    CS_SYNSENT   = 2'd1,
    CS_CONNECTED = 2'd2,
    CS_FINWAIT   = 2'd3
  } conn_state_e;

  typedef enum logic [1:0] {
    RK_REPLY    = 2'd0,
    RK_SEGMENT  = 2'd1,
    RK_CONN_DONE = 2'd2,
    RK_DISC_DONE = 2'd3
  } result_kind_e;

  localparam logic [1:0] TX_SYN    = 2'd0;
  localparam logic [1:0] TX_FIN    = 2'd2;
  localparam logic [2:0] RX_SYNACK = 3'd1;
  localparam logic [2:0] RX_FINACK = 3'd3;

  typedef enum logic [1:0] {
    CFG_SYN_RETRY   = 2'd0,
    CFG_FIN_RETRY   = 2'd1,
    CFG_SYN_TIMEOUT = 2'd2,
    CFG_FIN_TIMEOUT = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_EXEC  = 2'd2,
    ST_FLUSH = 2'd3
  } fsm_e;

  typedef struct packed {
    conn_state_e conn_state;
    logic [15:0] own_port;
    logic [15:0] peer_port;
    logic [15:0] next_sequence;
    logic [7:0]  sends_done;
    logic [15:0] wait_ticks;
  } entry_t;

  typedef struct packed {
    result_kind_e kind;
    logic [2:0]   sock;
    logic         success;
    logic [15:0]  from_port;
    logic [15:0]  to_port;
    logic [15:0]  seq;
    logic [1:0]   tx_kind;
  } result_t;

endpackage

@@ design/tcct_ram.sv @@
// Generic single-port-write, registered-read RAM.
module tcct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ design/transport_client_connection_table.sv @@
// Top level of the transport client connection table.
//
// Commands arrive on the s_axis channel, one transfer per command, and the
// block answers on the m_axis channel with one or more result transfers, or
// with none for an unknown opcode, a segment that completes no handshake or a
// tick with no entry due; tlast marks the final result of a command.
// Configuration writes use the cfg channel, which is always ready and must only
// be used while the block is idle. Per-entry state lives in one RAM with a
// registered read; the valid bits are flip-flops. A command is handled one at a
// time. Open, and a command to an entry that is not valid, go from idle to the
// flush state and back. Connect, disconnect and close go through the read,
// execute and flush states. A received segment scans the table, a read and an
// execute step per entry, up to the matching one; a tick always scans every entry.
// A result is held back in a pending register so that tlast can be set, and the
// scan stalls when a further result is ready while the output register is full
// and the receiver is not ready. Reset clears all valid bits, restores the
// register defaults and empties the output; the RAM needs no clearing pass.
module transport_client_connection_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sock_index, local_port, remote_port, rx_src_port, rx_dest_port, rx_ack
  input  logic [87:0] s_axis_tdata,
  // opcode, rx_kind
  input  logic [5:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_sock, tx_src_port, tx_dest_port, tx_seq
  output logic [55:0] m_axis_tdata,
  // result_kind, success, tx_kind
  output logic [4:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import tcct_pkg::*;

  localparam int unsigned EW = $bits(entry_t);

  fsm_e state_q, state_d;
  logic [CONNECTIONS-1:0] valid_q, valid_d;
  logic [7:0]  syn_limit_q, fin_limit_q;
  logic [15:0] syn_tmo_q, fin_tmo_q;

  opcode_e     op_q, op_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0] rport_q, rport_d, rxsrc_q, rxsrc_d, rxdst_q, rxdst_d, rxack_q, rxack_d;
  logic [2:0]  rxkind_q, rxkind_d;

  result_t pend_q, pend_d;
  logic    pend_vld_q, pend_vld_d;
  result_t out_q, out_d;
  logic    out_vld_q, out_vld_d, out_last_q, out_last_d;

  logic   ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  entry_t ram_wdata, ent;
  logic [EW-1:0] ram_rdata;

  logic accept, slot_free, stall, res_gen, done_scan, last_idx;
  result_t res;
  opcode_e in_op;
  logic [IDX_W-1:0] in_sock, free_idx;
  logic free_found;

  tcct_ram #(.WIDTH(EW), .DEPTH(CONNECTIONS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign ent           = entry_t'(ram_rdata);
  assign in_op         = opcode_e'(s_axis_tuser[2:0]);
  assign in_sock       = s_axis_tdata[2:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_vld_q || m_axis_tready;
  assign last_idx      = (idx_q == IDX_W'(CONNECTIONS - 1));
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CONNECTIONS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CONNECT, OP_DISCONNECT, OP_CLOSE:
              state_d = valid_q[in_sock] ? ST_READ : ST_FLUSH;
            OP_SEGMENT, OP_TICK: state_d = ST_READ;
            default:             state_d = ST_FLUSH;
          endcase
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (!stall) begin
          state_d = done_scan ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q || slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic syn, fin;
    logic [15:0] wt, tmo;
    logic [7:0]  lim;
    valid_d    = valid_q;
    op_d       = op_q;
    idx_d      = idx_q;
    rport_d    = rport_q;
    rxsrc_d    = rxsrc_q;
    rxdst_d    = rxdst_q;
    rxack_d    = rxack_q;
    rxkind_d   = rxkind_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_last_d = out_last_q;
    ram_we     = 1'b0;
    ram_re     = (state_q == ST_READ);
    ram_waddr  = idx_q;
    ram_wdata  = ent;
    res_gen    = 1'b0;
    res        = '0;
    done_scan  = 1'b0;
    stall      = 1'b0;
    syn        = (ent.conn_state == CS_SYNSENT);
    fin        = (ent.conn_state == CS_FINWAIT);
    wt         = (ent.wait_ticks != 16'hFFFF) ? ent.wait_ticks + 16'd1 : ent.wait_ticks;
    tmo        = syn ? syn_tmo_q : fin_tmo_q;
    lim        = syn ? syn_limit_q : fin_limit_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d       = in_op;
          rport_d    = s_axis_tdata[34:19];
          rxsrc_d    = s_axis_tdata[50:35];
          rxdst_d    = s_axis_tdata[66:51];
          rxack_d    = s_axis_tdata[82:67];
          rxkind_d   = s_axis_tuser[5:3];
          pend_vld_d = 1'b0;
          idx_d      = '0;
          pend_d     = '0;
          case (in_op)
            OP_OPEN: begin
              pend_vld_d = 1'b1;
              pend_d.kind = RK_REPLY;
              if (free_found) begin
                valid_d[free_idx]       = 1'b1;
                ram_we                  = 1'b1;
                ram_waddr               = free_idx;
                ram_wdata               = '0;
                ram_wdata.conn_state    = CS_CLOSED;
                ram_wdata.own_port      = s_axis_tdata[18:3];
                pend_d.sock             = free_idx;
                pend_d.success          = 1'b1;
              end
            end
            OP_CONNECT, OP_DISCONNECT, OP_CLOSE: begin
              idx_d = in_sock;
              if (!valid_q[in_sock]) begin
                pend_vld_d     = 1'b1;
                pend_d.sock    = in_sock;
                pend_d.kind    = (in_op == OP_CONNECT) ? RK_CONN_DONE :
                                 (in_op == OP_DISCONNECT) ? RK_DISC_DONE : RK_REPLY;
                pend_d.success = (in_op == OP_CLOSE);
              end
            end
            default: ;
          endcase
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_CONNECT, OP_DISCONNECT: begin
            done_scan = 1'b1;
            res_gen   = 1'b1;
            res.kind  = RK_SEGMENT;
            res.sock  = idx_q;
            res.from_port = ent.own_port;
            res.seq   = ent.next_sequence;
            ram_wdata.next_sequence = (ent.next_sequence == SEQ_MAX) ? 16'd0 :
                                      ent.next_sequence + 16'd1;
            ram_wdata.sends_done = 8'd1;
            ram_wdata.wait_ticks = '0;
            if (op_q == OP_CONNECT) begin
              ram_wdata.peer_port  = rport_q;
              ram_wdata.conn_state = CS_SYNSENT;
              res.to_port          = rport_q;
              res.tx_kind          = TX_SYN;
            end else begin
              ram_wdata.conn_state = CS_FINWAIT;
              res.to_port          = ent.peer_port;
              res.tx_kind          = TX_FIN;
            end
          end
          OP_CLOSE: begin
            done_scan = 1'b1;
            res_gen   = 1'b1;
            res.kind  = RK_REPLY;
            res.sock  = idx_q;
            if (ent.conn_state == CS_CLOSED) begin
              res.success = 1'b1;
            end
          end
          OP_SEGMENT: begin
            done_scan = last_idx;
            if (valid_q[idx_q] && ent.peer_port == rxsrc_q && ent.own_port == rxdst_q) begin
              done_scan = 1'b1;
              res.sock  = idx_q;
              res.success = 1'b1;
              if (rxack_q == ent.next_sequence) begin
                if (syn && rxkind_q == RX_SYNACK) begin
                  res_gen = 1'b1;
                  res.kind = RK_CONN_DONE;
                  ram_wdata.conn_state = CS_CONNECTED;
                end else if (fin && rxkind_q == RX_FINACK) begin
                  res_gen = 1'b1;
                  res.kind = RK_DISC_DONE;
                  ram_wdata.conn_state = CS_CLOSED;
                end
              end
            end
          end
          OP_TICK: begin
            done_scan = last_idx;
            if (valid_q[idx_q] && (syn || fin)) begin
              ram_wdata.wait_ticks = wt;
              if (wt >= tmo) begin
                res_gen  = 1'b1;
                res.sock = idx_q;
                if (ent.sends_done < lim) begin
                  ram_wdata.sends_done = ent.sends_done + 8'd1;
                  ram_wdata.wait_ticks = '0;
                  res.kind      = RK_SEGMENT;
                  res.from_port = ent.own_port;
                  res.to_port   = ent.peer_port;
                  res.seq       = (ent.next_sequence == 16'd0) ? SEQ_MAX :
                                  ent.next_sequence - 16'd1;
                  res.tx_kind   = syn ? TX_SYN : TX_FIN;
                end else begin
                  ram_wdata.conn_state = CS_CLOSED;
                  res.kind = syn ? RK_CONN_DONE : RK_DISC_DONE;
                end
              end
            end
          end
          default: done_scan = 1'b1;
        endcase

        stall = res_gen && pend_vld_q && !slot_free;
        if (!stall) begin
          if (op_q == OP_SEGMENT || op_q == OP_TICK) begin
            ram_we = res_gen || (op_q == OP_TICK && valid_q[idx_q] && (syn || fin));
          end else if (op_q == OP_CONNECT || op_q == OP_DISCONNECT) begin
            ram_we = 1'b1;
          end
          if (op_q == OP_CLOSE && ent.conn_state == CS_CLOSED) begin
            valid_d[idx_q] = 1'b0;
          end
          if (res_gen) begin
            if (pend_vld_q) begin
              out_d      = pend_q;
              out_vld_d  = 1'b1;
              out_last_d = 1'b0;
            end
            pend_d     = res;
            pend_vld_d = 1'b1;
          end
          if (!done_scan) begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (pend_vld_q && slot_free) begin
          out_d      = pend_q;
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      syn_limit_q <= 8'd5;
      fin_limit_q <= 8'd5;
      syn_tmo_q   <= 16'd100;
      fin_tmo_q   <= 16'd100;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_valid_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_SYN_RETRY:   syn_limit_q <= cfg_data_i[7:0];
          CFG_FIN_RETRY:   fin_limit_q <= cfg_data_i[7:0];
          CFG_SYN_TIMEOUT: syn_tmo_q   <= cfg_data_i;
          CFG_FIN_TIMEOUT: fin_tmo_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    rport_q    <= rport_d;
    rxsrc_q    <= rxsrc_d;
    rxdst_q    <= rxdst_d;
    rxack_q    <= rxack_d;
    rxkind_q   <= rxkind_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_q.seq, out_q.to_port, out_q.from_port, out_q.sock};
  assign m_axis_tuser  = {out_q.tx_kind, out_q.success, out_q.kind};

endmodule

@@ verif/transport_client_connection_table_checker.sv @@
// Checker that predicts and compares the results of the connection table.
module transport_client_connection_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,
  input  logic [5:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [4:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);
  import tcct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  sock;
    logic        success;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] seq;
    logic [1:0]  tx_kind;
    logic        last;
  } conn_result_t;

  logic [7:0]  syn_limit, fin_limit;
  logic [15:0] syn_tmo, fin_tmo;
  logic        vld [CONNECTIONS];
  conn_state_e cst [CONNECTIONS];
  logic [15:0] own [CONNECTIONS];
  logic [15:0] peer [CONNECTIONS];
  logic [15:0] nseq [CONNECTIONS];
  logic [7:0]  sends [CONNECTIONS];
  logic [15:0] ticks [CONNECTIONS];
  conn_result_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic conn_result_t mk(logic [1:0] k, logic [2:0] s, logic ok,
                                      logic [15:0] sp, logic [15:0] dp,
                                      logic [15:0] sq, logic [1:0] tk);
    conn_result_t r;
    r = '{k, s, ok, sp, dp, sq, tk, 1'b0};
    return r;
  endfunction

  task automatic predict_command(logic [87:0] d, logic [5:0] u);
    conn_result_t outs[$];
    logic [2:0]  op, rxk, sk;
    logic [15:0] lp, rp, rs, rd, ra;
    int i;
    bit ok, syn, fin;
    logic [7:0]  lim;
    logic [15:0] tmo;
    op = u[2:0]; rxk = u[5:3];
    sk = d[2:0]; lp = d[18:3]; rp = d[34:19];
    rs = d[50:35]; rd = d[66:51]; ra = d[82:67];
    ok = vld[sk];
    case (op)
      OP_OPEN: begin
        for (i = 0; i < CONNECTIONS; i++) if (!vld[i]) break;
        if (i == CONNECTIONS) begin
          outs.push_back(mk(RK_REPLY, 0, 0, 0, 0, 0, 0));
        end else begin
          vld[i] = 1; cst[i] = CS_CLOSED; own[i] = lp; peer[i] = 0;
          nseq[i] = 0; sends[i] = 0; ticks[i] = 0;
          outs.push_back(mk(RK_REPLY, 3'(i), 1, 0, 0, 0, 0));
        end
      end
      OP_CONNECT, OP_DISCONNECT: begin
        if (!ok) begin
          outs.push_back(mk(op == OP_CONNECT ? RK_CONN_DONE : RK_DISC_DONE,
                            sk, 0, 0, 0, 0, 0));
        end else begin
          if (op == OP_CONNECT) peer[sk] = rp;
          outs.push_back(mk(RK_SEGMENT, sk, 0, own[sk], peer[sk], nseq[sk],
                            op == OP_CONNECT ? TX_SYN : TX_FIN));
          nseq[sk] = nseq[sk] + 16'd1;
          cst[sk] = op == OP_CONNECT ? CS_SYNSENT : CS_FINWAIT;
          sends[sk] = 1; ticks[sk] = 0;
        end
      end
      OP_CLOSE: begin
        if (!ok) begin
          outs.push_back(mk(RK_REPLY, sk, 1, 0, 0, 0, 0));
        end else if (cst[sk] != CS_CLOSED) begin
          outs.push_back(mk(RK_REPLY, sk, 0, 0, 0, 0, 0));
        end else begin
          vld[sk] = 0;
          outs.push_back(mk(RK_REPLY, sk, 1, 0, 0, 0, 0));
        end
      end
      OP_SEGMENT: begin
        for (i = 0; i < CONNECTIONS; i++)
          if (vld[i] && peer[i] == rs && own[i] == rd) break;
        if (i < CONNECTIONS && ra == nseq[i]) begin
          if (cst[i] == CS_SYNSENT && rxk == RX_SYNACK) begin
            cst[i] = CS_CONNECTED;
            outs.push_back(mk(RK_CONN_DONE, 3'(i), 1, 0, 0, 0, 0));
          end else if (cst[i] == CS_FINWAIT && rxk == RX_FINACK) begin
            cst[i] = CS_CLOSED;
            outs.push_back(mk(RK_DISC_DONE, 3'(i), 1, 0, 0, 0, 0));
          end
        end
      end
      OP_TICK: begin
        for (i = 0; i < CONNECTIONS && outs.size() < 8; i++) begin
          syn = cst[i] == CS_SYNSENT;
          fin = cst[i] == CS_FINWAIT;
          if (!vld[i] || (!syn && !fin)) continue;
          lim = syn ? syn_limit : fin_limit;
          tmo = syn ? syn_tmo : fin_tmo;
          if (ticks[i] != 16'hFFFF) ticks[i]++;
          if (ticks[i] < tmo) continue;
          if (sends[i] < lim) begin
            sends[i]++; ticks[i] = 0;
            outs.push_back(mk(RK_SEGMENT, 3'(i), 0, own[i], peer[i], nseq[i] - 16'd1,
                              syn ? TX_SYN : TX_FIN));
          end else begin
            cst[i] = CS_CLOSED;
            outs.push_back(mk(syn ? RK_CONN_DONE : RK_DISC_DONE, 3'(i), 0, 0, 0, 0, 0));
          end
        end
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[outs.size() - 1].last = 1;
    foreach (outs[k]) expected_results.push_back(outs[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    conn_result_t got, want;
    if (!rst_ni) begin
      syn_limit = 5; fin_limit = 5; syn_tmo = 100; fin_tmo = 100;
      foreach (vld[i]) begin
        vld[i] = 0; cst[i] = CS_CLOSED; own[i] = 0; peer[i] = 0;
        nseq[i] = 0; sends[i] = 0; ticks[i] = 0;
      end
      expected_results.delete();
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_SYN_RETRY:   syn_limit = cfg_data_i[7:0];
          CFG_FIN_RETRY:   fin_limit = cfg_data_i[7:0];
          CFG_SYN_TIMEOUT: syn_tmo = cfg_data_i;
          CFG_FIN_TIMEOUT: fin_tmo = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser[1:0], m_axis_tdata[2:0], m_axis_tuser[2],
                m_axis_tdata[18:3], m_axis_tdata[34:19], m_axis_tdata[50:35],
                m_axis_tuser[4:3], m_axis_tlast};
        results_o <= results_o + 1;
        if (expected_results.size() == 0) begin
          if (errors_o < 10) $display("unexpected result %h", got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (errors_o < 10)
              $display("mismatch: expected %h actual %h", want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_command(s_axis_tdata, s_axis_tuser);
    end
  end
endmodule

@@ verif/transport_client_connection_table_tb.sv @@
// Testbench top: drives commands and configuration and reports the verdict.
module transport_client_connection_table_tb;
  import tcct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [5:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [55:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  int          errors, pending, results, sent;
  logic [15:0] port_pool [4];

  transport_client_connection_table dut (.*);
  transport_client_connection_table_checker u_checker (
    .*, .errors_o(errors), .pending_o(pending), .results_o(results));

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sent > 60 && sent < 90) m_axis_tready <= 1;
      else m_axis_tready <= gap_len() == 0;
    end
  end

  task automatic send_cmd(opcode_e op, logic [2:0] sk, logic [15:0] lp, logic [15:0] rp,
                          logic [15:0] rs, logic [15:0] rd, logic [2:0] rk,
                          logic [15:0] ra);
    int g;
    g = (sent > 60 && sent < 90) ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {5'd0, ra, rd, rs, rp, lp, sk};
    s_axis_tuser  <= {rk, 3'(op)};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic write_cfg(cfg_index_e idx, logic [15:0] val);
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  task automatic random_cmd();
    int r, p, q;
    logic [2:0] sk;
    r = $urandom_range(0, 99);
    sk = 3'($urandom);
    p = $urandom_range(0, 3);
    q = $urandom_range(0, 3);
    if (r < 15)
      send_cmd(OP_OPEN, 3'($urandom), port_pool[p], 16'($urandom), 16'($urandom),
               16'($urandom), 3'($urandom), 16'($urandom));
    else if (r < 30)
      send_cmd(OP_CONNECT, sk, 16'($urandom), port_pool[q], 16'($urandom), 16'($urandom),
               3'($urandom), 16'($urandom));
    else if (r < 38)
      send_cmd(OP_DISCONNECT, sk, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 3'($urandom), 16'($urandom));
    else if (r < 48)
      send_cmd(OP_CLOSE, sk, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               3'($urandom), 16'($urandom));
    else if (r < 70)
      send_cmd(OP_SEGMENT, 3'($urandom), 16'($urandom), 16'($urandom), port_pool[q],
               port_pool[p],
               $urandom_range(0, 1) ? RX_SYNACK : ($urandom_range(0, 1) ? RX_FINACK
               : 3'($urandom)), $urandom_range(0, 2) ? 16'($urandom_range(0, 3))
               : 16'($urandom));
    else if (r < 97)
      send_cmd(OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 3'($urandom), 16'($urandom));
    else
      send_cmd(opcode_e'(3'($urandom_range(6, 7))), 3'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom), 16'($urandom));
  endtask

  initial begin
    int k;
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    sent = 0;
    port_pool = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part at small limits so that retries and give-ups show up.
    write_cfg(CFG_SYN_RETRY, 1);
    write_cfg(CFG_FIN_RETRY, 2);
    write_cfg(CFG_SYN_TIMEOUT, 1);
    write_cfg(CFG_FIN_TIMEOUT, 1);
    send_cmd(OP_CLOSE, 3'd7, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_CONNECT, 3'd2, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_DISCONNECT, 3'd5, 0, 0, 0, 0, 0, 0);
    for (k = 0; k < 9; k++)
      send_cmd(OP_OPEN, 0, k[0] ? 16'hFFFF : 16'h0000, 0, 0, 0, 0, 0);
    send_cmd(OP_CONNECT, 3'd0, 0, 16'hFFFF, 0, 0, 0, 0);
    send_cmd(OP_SEGMENT, 0, 0, 0, 16'hFFFF, 16'h0000, RX_SYNACK, 16'hFFFF);
    send_cmd(OP_SEGMENT, 0, 0, 0, 16'hFFFF, 16'h0000, RX_SYNACK, 16'd1);
    send_cmd(OP_CLOSE, 3'd0, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_DISCONNECT, 3'd0, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_SEGMENT, 0, 0, 0, 16'hFFFF, 16'h0000, RX_FINACK, 16'd2);
    send_cmd(OP_CLOSE, 3'd0, 0, 0, 0, 0, 0, 0);
    for (k = 1; k < 8; k++) send_cmd(OP_CONNECT, 3'(k), 0, 16'hFFFF, 0, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(opcode_e'(3'd6), 0, 0, 0, 0, 0, 0, 0);
    send_cmd(opcode_e'(3'd7), 0, 0, 0, 0, 0, 0, 0);

    // Random phases under several register settings, extremes included.
    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin write_cfg(CFG_SYN_RETRY, 3); write_cfg(CFG_SYN_TIMEOUT, 2);
                 write_cfg(CFG_FIN_RETRY, 255); write_cfg(CFG_FIN_TIMEOUT, 3); end
        1: begin write_cfg(CFG_SYN_RETRY, 255); write_cfg(CFG_SYN_TIMEOUT, 1);
                 write_cfg(CFG_FIN_RETRY, 1); write_cfg(CFG_FIN_TIMEOUT, 1); end
        2: begin write_cfg(CFG_SYN_TIMEOUT, 65535); write_cfg(CFG_FIN_TIMEOUT, 65535); end
        default: begin write_cfg(CFG_SYN_RETRY, 2); write_cfg(CFG_SYN_TIMEOUT, 4);
                 write_cfg(CFG_FIN_RETRY, 4); write_cfg(CFG_FIN_TIMEOUT, 2); end
      endcase
      repeat (k == 2 ? 20 : 37) random_cmd();
    end
    s_axis_tvalid <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d commands through open, connect, disconnect, close, segment and tick,",
             sent);
    $display("checking %0d results under five register settings.", results);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

@@ transport_client_connection_table.f @@
design/tcct_pkg.sv
design/tcct_ram.sv
design/transport_client_connection_table.sv
verif/transport_client_connection_table_checker.sv
verif/transport_client_connection_table_tb.sv
